FILE: sv/dnd_pkg.sv
// Shared types, codes, constants and helpers of the DNS name decompressor.
package dnd_pkg;

  // Default sizing of the packet store and the pointer jump limit.
  localparam int unsigned DEF_PACKET_BYTES = 512;
  localparam int unsigned DEF_MAX_JUMPS    = 16;

  // Label and pointer encoding of the wire format.
  localparam int unsigned LABEL_MAX  = 63;
  localparam int unsigned PTR_MARK   = 192;
  localparam int unsigned PTR_SHIFT  = 8;
  localparam int unsigned NAME_LIMIT = 255;
  localparam int unsigned LBL_BITS   = $clog2(LABEL_MAX + 1);
  localparam int unsigned PTR_BITS   = LBL_BITS + PTR_SHIFT;

  // The decoded name store holds one uncompressed name.
  localparam int unsigned NAME_DEPTH = 256;
  localparam int unsigned NAME_AW    = $clog2(NAME_DEPTH);

  // Request action codes.
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DECODE = 2'd1,
    ACT_READ   = 2'd2
  } act_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PAST_END  = 3'd1,
    ST_BAD_PTR   = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_JUMPS     = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FETCH,
    S_LEN,
    S_PTR,
    S_CHAR
  } dnd_state_t;

  // Lowercase an ASCII letter; every other byte passes unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: sv/dnd_if.sv
// Request and response channel interfaces of the DNS name decompressor.
interface dnd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] packet_byte;
  logic       first_byte;
  logic [8:0] start_offset;
  logic [7:0] read_index;

  modport source (output valid, action, packet_byte, first_byte, start_offset, read_index,
                  input ready);
  modport sink (input valid, action, packet_byte, first_byte, start_offset, read_index,
                output ready);
endinterface

interface dnd_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] end_offset;
  logic [7:0] name_length;
  logic [7:0] read_byte;

  modport source (output valid, status, end_offset, name_length, read_byte, input ready);
  modport sink (input valid, status, end_offset, name_length, read_byte, output ready);
endinterface

FILE: sv/dns_name_decompressor_unit.sv
// DNS name decompressor: packet store, label and pointer walker, decoded name store.
//
// Load beats write one packet byte each and answer in the cycle after they are taken; an
// unused action is taken and answers nothing. A read beat passes the S_READ state, where
// the name store returns its byte, and its answer is then registered in the output
// register. A decode beat occupies the block until its result is in the output register:
// each length or terminator byte passes S_FETCH and S_LEN (fetch, then decode), each label
// character S_CHAR, and the second byte of every pointer followed S_PTR. The walk is paced
// by the single read port of the packet store, which delivers one byte per cycle to the
// one walking sequencer. At the earliest, the next beat is taken in the cycle that the
// pending result leaves the output register; no beat is taken while a result waits unread
// or while a decode or read is still in progress.
module dns_name_decompressor_unit
  import dnd_pkg::*;
#(
  parameter int unsigned PACKET_BYTES = DEF_PACKET_BYTES,
  parameter int unsigned MAX_JUMPS    = DEF_MAX_JUMPS
) (
  input logic       clk,
  input logic       rst,
  dnd_req_if.sink   req,
  dnd_rsp_if.source rsp
);

  localparam int unsigned AW   = $clog2(PACKET_BYTES);
  localparam int unsigned CNTW = $clog2(PACKET_BYTES + 1);
  localparam int unsigned CW   = (PTR_BITS > CNTW) ? PTR_BITS : CNTW;
  localparam int unsigned CW1  = CW + 1;
  localparam int unsigned JW   = $clog2(MAX_JUMPS + 1);

  // Control state.
  dnd_state_t state, state_next;
  logic       out_valid, out_valid_next;
  logic [CNTW-1:0] count, count_next;
  logic [NAME_AW-1:0] fill, fill_next;

  // Walk registers.
  logic [CW-1:0]       cur, cur_next;
  logic [CW-1:0]       outer, outer_next;
  logic [7:0]          sum, sum_next;
  logic [JW-1:0]       jumps, jumps_next;
  logic                jumped, jumped_next;
  logic [LBL_BITS-1:0] ptr_hi, ptr_hi_next;
  logic [LBL_BITS-1:0] remain, remain_next;
  logic                rd_hit, rd_hit_next;

  // Output register payload.
  status_t    out_status, out_status_next;
  logic [9:0] out_end, out_end_next;
  logic [7:0] out_len, out_len_next;
  logic [7:0] out_rbyte, out_rbyte_next;

  // Memory ports.
  logic               pkt_we;
  logic [AW-1:0]      pkt_waddr, pkt_raddr;
  logic [7:0]         pkt_wdata, pkt_rdata;
  logic               name_we;
  logic [NAME_AW-1:0] name_waddr, name_raddr;
  logic [7:0]         name_wdata, name_rdata;

  // Decode helpers.
  logic            accept;
  logic [CW-1:0]   count_ext;
  logic [CW-1:0]   cur_inc;
  logic            at_end;
  logic            len_zero;
  logic            len_ptr;
  logic            ptr_bad;
  logic [CW1-1:0]  label_end;
  logic            label_over;
  logic [9:0]      name_grow;
  logic            name_over;
  logic            jump_lim;
  logic [PTR_BITS-1:0] target;
  logic [CNTW-1:0] load_base;
  logic            load_full;
  logic            finish;
  status_t         fin_status;

  dnd_ram #(.DEPTH(PACKET_BYTES), .WIDTH(8)) u_pkt_ram (
    .clk   (clk),
    .we    (pkt_we),
    .waddr (pkt_waddr),
    .wdata (pkt_wdata),
    .raddr (pkt_raddr),
    .rdata (pkt_rdata)
  );

  dnd_ram #(.DEPTH(NAME_DEPTH), .WIDTH(8)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (name_wdata),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  // Handshake: take a beat only when idle and the output slot is free or draining.
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.end_offset  = out_end;
  assign rsp.name_length = out_len;
  assign rsp.read_byte   = out_rbyte;

  // Cursor, label and pointer checks on the byte just returned by the packet store.
  assign count_ext  = CW'(count);
  assign cur_inc    = cur + CW'(1);
  assign at_end     = cur >= count_ext;
  assign len_zero   = pkt_rdata == 8'd0;
  assign len_ptr    = pkt_rdata > 8'(LABEL_MAX);
  assign ptr_bad    = (pkt_rdata < 8'(PTR_MARK)) || (cur_inc >= count_ext);
  assign label_end  = CW1'(cur_inc) + CW1'(pkt_rdata);
  assign label_over = label_end > CW1'(count);
  assign name_grow  = 10'(sum) + 10'(pkt_rdata) + 10'd2;
  assign name_over  = name_grow > 10'(NAME_LIMIT);
  assign jump_lim   = jumps >= JW'(MAX_JUMPS);
  assign target     = {ptr_hi, pkt_rdata};
  assign load_base  = req.first_byte ? '0 : count;
  assign load_full  = load_base >= CNTW'(PACKET_BYTES);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (act_t'(req.action))
            ACT_DECODE: state_next = S_FETCH;
            ACT_READ:   state_next = S_READ;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ:  state_next = S_IDLE;
      S_FETCH: state_next = at_end ? S_IDLE : S_LEN;
      S_LEN: begin
        if (len_zero) begin
          state_next = S_IDLE;
        end else if (len_ptr) begin
          state_next = ptr_bad ? S_IDLE : S_PTR;
        end else begin
          state_next = (label_over || name_over) ? S_IDLE : S_CHAR;
        end
      end
      S_PTR:   state_next = jump_lim ? S_IDLE : S_FETCH;
      S_CHAR:  state_next = (remain == LBL_BITS'(1)) ? S_FETCH : S_CHAR;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and output logic of the sequencer.
  always_comb begin
    count_next      = count;
    fill_next       = fill;
    cur_next        = cur;
    outer_next      = outer;
    sum_next        = sum;
    jumps_next      = jumps;
    jumped_next     = jumped;
    ptr_hi_next     = ptr_hi;
    remain_next     = remain;
    rd_hit_next     = rd_hit;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_end_next    = out_end;
    out_len_next    = out_len;
    out_rbyte_next  = out_rbyte;
    pkt_we          = 1'b0;
    pkt_waddr       = load_base[AW-1:0];
    pkt_wdata       = req.packet_byte;
    pkt_raddr       = cur[AW-1:0];
    name_we         = 1'b0;
    name_waddr      = fill;
    name_wdata      = pkt_rdata;
    name_raddr      = req.read_index;
    finish          = 1'b0;
    fin_status      = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (act_t'(req.action))
            ACT_LOAD: begin
              count_next      = load_base;
              out_valid_next  = 1'b1;
              out_status_next = ST_OK;
              out_end_next    = '0;
              out_len_next    = '0;
              out_rbyte_next  = '0;
              if (load_full) begin
                out_status_next = ST_FULL;
              end else begin
                pkt_we     = 1'b1;
                count_next = load_base + CNTW'(1);
              end
            end
            ACT_DECODE: begin
              cur_next    = CW'(req.start_offset);
              outer_next  = CW'(req.start_offset);
              sum_next    = '0;
              fill_next   = '0;
              jumps_next  = '0;
              jumped_next = 1'b0;
            end
            ACT_READ: begin
              rd_hit_next = req.read_index < fill;
            end
            default: begin
            end
          endcase
        end
      end

      // Name store byte is back; answer the read.
      S_READ: begin
        out_valid_next  = 1'b1;
        out_status_next = rd_hit ? ST_OK : ST_PAST_END;
        out_end_next    = '0;
        out_len_next    = '0;
        out_rbyte_next  = rd_hit ? name_rdata : 8'd0;
      end

      // Stop at the packet end, otherwise the read of cur is already on the port.
      S_FETCH: begin
        if (at_end) begin
          finish     = 1'b1;
          fin_status = ST_PAST_END;
        end
      end

      // Length, terminator or pointer byte.
      S_LEN: begin
        cur_next = cur_inc;
        if (!jumped) begin
          outer_next = cur_inc;
        end
        if (len_zero) begin
          name_we    = 1'b1;
          name_wdata = 8'd0;
          fill_next  = fill + NAME_AW'(1);
          finish     = 1'b1;
          fin_status = ST_OK;
        end else if (len_ptr) begin
          if (ptr_bad) begin
            finish     = 1'b1;
            fin_status = ST_BAD_PTR;
          end else begin
            ptr_hi_next = pkt_rdata[LBL_BITS-1:0];
            pkt_raddr   = cur_inc[AW-1:0];
          end
        end else if (label_over) begin
          finish     = 1'b1;
          fin_status = ST_OVERRUN;
        end else if (name_over) begin
          finish     = 1'b1;
          fin_status = ST_TOO_LONG;
        end else begin
          name_we     = 1'b1;
          name_wdata  = pkt_rdata;
          fill_next   = fill + NAME_AW'(1);
          sum_next    = 8'(name_grow - 10'd1);
          remain_next = pkt_rdata[LBL_BITS-1:0];
          pkt_raddr   = cur_inc[AW-1:0];
        end
      end

      // Second pointer byte: follow the jump unless the limit is reached.
      S_PTR: begin
        if (!jumped) begin
          outer_next  = cur_inc;
          jumped_next = 1'b1;
        end
        if (jump_lim) begin
          finish     = 1'b1;
          fin_status = ST_JUMPS;
        end else begin
          jumps_next = jumps + JW'(1);
          cur_next   = CW'(target);
        end
      end

      // One label character per cycle, lowercased into the name store.
      S_CHAR: begin
        name_we     = 1'b1;
        name_wdata  = fold_case(pkt_rdata);
        fill_next   = fill + NAME_AW'(1);
        cur_next    = cur_inc;
        remain_next = remain - LBL_BITS'(1);
        pkt_raddr   = cur_inc[AW-1:0];
      end

      default: begin
      end
    endcase

    // Decode result goes to the output register when the walk ends.
    if (finish) begin
      out_valid_next  = 1'b1;
      out_status_next = fin_status;
      out_end_next    = 10'(outer_next);
      out_len_next    = sum_next;
      out_rbyte_next  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      fill      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      count     <= count_next;
      fill      <= fill_next;
    end
  end

  // Walk and output payload registers.
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    outer      <= outer_next;
    sum        <= sum_next;
    jumps      <= jumps_next;
    jumped     <= jumped_next;
    ptr_hi     <= ptr_hi_next;
    remain     <= remain_next;
    rd_hit     <= rd_hit_next;
    out_status <= out_status_next;
    out_end    <= out_end_next;
    out_len    <= out_len_next;
    out_rbyte  <= out_rbyte_next;
  end

  // No beat is taken while a decode or read is in progress.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("request taken while the sequencer is busy");

  // The output slot stays empty during a walk, so the final result never overwrites one.
  a_walk_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH || state == S_LEN || state == S_PTR || state == S_CHAR) |-> !out_valid)
    else $error("output register occupied during a decode walk");

  // The packet fill count never passes the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(PACKET_BYTES))
    else $error("packet count beyond the packet store");

  // A character run always has characters left.
  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHAR) |-> (remain != '0))
    else $error("character state entered with no characters left");

  // A read answers in the cycle after its S_READ state.
  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> out_valid)
    else $error("read beat produced no result");

endmodule

FILE: sv/dnd_ram.sv
// Simple dual-port RAM: one write port and one read port with registered read data.
module dnd_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: bench/dnd_check_pkg.sv
// Scoreboard of the DNS name decompressor bench: name walk prediction and result checks.
package dnd_check_pkg;
  import dnd_pkg::*;

  // Action code that the block takes without answering.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    status_t    status;
    logic [9:0] end_offset;
    logic [7:0] name_length;
    logic [7:0] read_byte;
  } name_result_t;

  class name_decode_checker;
    logic [7:0]   packet_mem [DEF_PACKET_BYTES];
    int unsigned  packet_count = 0;
    logic [7:0]   name_mem [NAME_DEPTH];
    int unsigned  name_count = 0;
    name_result_t pending_results [$];
    int unsigned  mismatches = 0;

    // Walk labels and pointers from start, rebuilding the uncompressed name.
    function name_result_t walk_labels(int unsigned start);
      name_result_t r;
      int unsigned  cur, outer, sum, fill, jumps, target, b, i;
      logic [7:0]   ch;
      bit           jumped, done;
      cur = start;
      outer = start;
      sum = 0;
      fill = 0;
      jumps = 0;
      jumped = 1'b0;
      done = 1'b0;
      r.status = ST_OK;
      while (!done) begin
        if (cur >= packet_count) begin
          r.status = ST_PAST_END;
          done = 1'b1;
        end else begin
          b = packet_mem[cur];
          cur++;
          if (!jumped) outer = cur;
          if (b == 0) begin
            // Terminator of the name.
            name_mem[fill % NAME_DEPTH] = 8'h00;
            fill++;
            done = 1'b1;
          end else if (b > LABEL_MAX) begin
            // Compression pointer, or a reserved length code.
            if (b < PTR_MARK || cur >= packet_count) begin
              r.status = ST_BAD_PTR;
              done = 1'b1;
            end else begin
              target = ((b & LABEL_MAX) << PTR_SHIFT) | packet_mem[cur];
              cur++;
              if (!jumped) begin
                outer = cur;
                jumped = 1'b1;
              end
              if (jumps >= DEF_MAX_JUMPS) begin
                r.status = ST_JUMPS;
                done = 1'b1;
              end else begin
                jumps++;
                cur = target;
              end
            end
          end else if (cur + b > packet_count) begin
            r.status = ST_OVERRUN;
            done = 1'b1;
          end else if (sum + b + 2 > NAME_LIMIT) begin
            r.status = ST_TOO_LONG;
            done = 1'b1;
          end else begin
            // Copy the label, folding upper-case letters.
            name_mem[fill % NAME_DEPTH] = 8'(b);
            fill++;
            for (i = 0; i < b; i++) begin
              ch = packet_mem[cur + i];
              if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
              name_mem[fill % NAME_DEPTH] = ch;
              fill++;
            end
            cur += b;
            sum += b + 1;
          end
        end
      end
      name_count = fill;
      r.end_offset = 10'(outer);
      r.name_length = 8'(sum);
      r.read_byte = 8'h00;
      return r;
    endfunction

    // Queue an expected answer behind the ones already waiting.
    function void queue_answer(name_result_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Update the model with an accepted request beat and queue its answer.
    function void note_request(logic [1:0] action, logic [7:0] packet_byte,
                               logic first_byte, logic [8:0] start_offset,
                               logic [7:0] read_index);
      name_result_t r;
      r.status = ST_OK;
      r.end_offset = '0;
      r.name_length = '0;
      r.read_byte = '0;
      case (action)
        ACT_LOAD: begin
          if (first_byte) packet_count = 0;
          if (packet_count >= DEF_PACKET_BYTES) begin
            r.status = ST_FULL;
          end else begin
            packet_mem[packet_count] = packet_byte;
            packet_count++;
          end
          queue_answer(r);
        end
        ACT_DECODE: begin
          queue_answer(walk_labels(start_offset));
        end
        ACT_READ: begin
          if (read_index < name_count) r.read_byte = name_mem[read_index];
          else r.status = ST_PAST_END;
          queue_answer(r);
        end
        default: begin
          // The unused action answers nothing.
        end
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare a response beat with the oldest expected answer.
    task check_result(logic [2:0] status, logic [9:0] end_offset, logic [7:0] name_length,
                      logic [7:0] read_byte);
      name_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("response beat with no answer expected");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
        if (end_offset !== want.end_offset)
          report_mismatch($sformatf("end_offset got %0d expected %0d", end_offset,
                                    want.end_offset));
        if (name_length !== want.name_length)
          report_mismatch($sformatf("name_length got %0d expected %0d", name_length,
                                    want.name_length));
        if (read_byte !== want.read_byte)
          report_mismatch($sformatf("read_byte got %0h expected %0h", read_byte,
                                    want.read_byte));
      end
    endtask
  endclass

endpackage

FILE: bench/tb_top.sv
// Top-level bench of the DNS name decompressor: stimulus, handshakes, checks and watchdog.
module tb_top;
  import dnd_pkg::*;
  import dnd_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned FULL_BODY   = DEF_PACKET_BYTES - 3;

  // Hand-made packet: a plain name, the root, a pointer name, a pointer loop, a reserved
  // length code, a pointer out of the packet and a label cut off by the packet end.
  localparam logic [7:0] DEMO_PKT [19] = '{
    8'h03, 8'h41, 8'h62, 8'h5A, 8'h02, 8'h63, 8'h6F, 8'h00,  // "AbZ" "co" root
    8'h01, 8'h78, 8'hC0, 8'h00,                              // "x" then pointer to 0
    8'hC0, 8'h0C,                                            // pointer to itself
    8'h40,                                                   // reserved length code
    8'hFF, 8'hFF,                                            // pointer far past the end
    8'h3F, 8'h61                                             // 63-byte label, one byte
  };

  logic clk;
  logic rst;

  dnd_req_if req_ch ();
  dnd_rsp_if rsp_ch ();

  dns_name_decompressor_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  name_decode_checker sb = new();

  int unsigned items_sent   = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  wire_buf [$];
  int unsigned name_starts [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request beat and wait until the block takes it.
  task automatic send_req(input logic [1:0] action, input logic [7:0] pbyte,
                          input logic first, input logic [8:0] start,
                          input logic [7:0] ridx);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.action = action;
    req_ch.packet_byte = pbyte;
    req_ch.first_byte = first;
    req_ch.start_offset = start;
    req_ch.read_index = ridx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(action, pbyte, first, start, ridx);
    if (action != ACT_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [7:0] b, input logic first);
    send_req(ACT_LOAD, b, first, 9'($urandom), 8'($urandom));
  endtask

  task automatic decode_at(input logic [8:0] start);
    send_req(ACT_DECODE, 8'($urandom), 1'($urandom), start, 8'($urandom));
  endtask

  task automatic read_at(input logic [7:0] idx);
    send_req(ACT_READ, 8'($urandom), 1'($urandom), 9'($urandom), idx);
  endtask

  // Label character: letters of both cases, digits, or any byte.
  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 3))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom);
    endcase
  endfunction

  // Add one byte at the end of the wire buffer.
  function automatic void append_byte(input logic [7:0] b);
    wire_buf.insert(wire_buf.size(), b);
  endfunction

  // Note the offset where a name begins.
  function automatic void note_start(input int unsigned start);
    name_starts.insert(name_starts.size(), start);
  endfunction

  function automatic void push_pointer(input int unsigned target);
    append_byte(8'(PTR_MARK | (target >> PTR_SHIFT)));
    append_byte(8'(target));
  endfunction

  // One label followed by a pointer back to its own start.
  function automatic void append_loop_name(input int unsigned len);
    int unsigned start;
    start = wire_buf.size();
    note_start(start);
    append_byte(8'(len));
    repeat (len) append_byte(random_char());
    push_pointer(start);
  endfunction

  // A name of a few labels, ended by the root, a pointer back or a stray pointer.
  function automatic void append_name();
    int unsigned start, len, pick;
    start = wire_buf.size();
    if ($urandom_range(0, 99) < 8) begin
      append_loop_name(($urandom_range(0, 1) == 1) ? LABEL_MAX : $urandom_range(1, 20));
    end else begin
      note_start(start);
      repeat ($urandom_range(0, 4)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, LABEL_MAX)
                                          : $urandom_range(1, 8);
        append_byte(8'(len));
        repeat (len) append_byte(random_char());
      end
      pick = $urandom_range(0, 99);
      if (pick < 30 && name_starts.size() > 1)
        push_pointer(name_starts[$urandom_range(0, name_starts.size() - 2)]);
      else if (pick < 36)
        push_pointer($urandom_range(0, 16383));
      else
        append_byte(8'h00);
      // Now and then a corrupted byte inside the name.
      if ($urandom_range(0, 14) == 0)
        wire_buf[$urandom_range(start, wire_buf.size() - 1)] = 8'($urandom);
    end
  endfunction

  // Fill the wire buffer with names and cut it to the given size.
  function automatic void build_packet(input int unsigned size, input bit lead_loop);
    wire_buf.delete();
    name_starts.delete();
    if (lead_loop) append_loop_name(LABEL_MAX);
    while (wire_buf.size() < size) append_name();
    while (wire_buf.size() > size) void'(wire_buf.pop_back());
  endfunction

  task automatic load_packet();
    foreach (wire_buf[i]) load_byte(wire_buf[i], i == 0);
  endtask

  // Decodes, mostly at name starts, each followed by a few reads of the name.
  task automatic exercise_names(input int unsigned decodes);
    int unsigned pick, start;
    repeat (decodes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && name_starts.size() > 0)
        start = name_starts[$urandom_range(0, name_starts.size() - 1)];
      else if (pick < 85)
        start = $urandom_range(0, wire_buf.size());
      else
        start = $urandom_range(0, 511);
      decode_at(9'(start));
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 4) == 0) read_at(8'($urandom));
        else read_at(8'($urandom_range(0, sb.name_count)));
      end
      if ($urandom_range(0, 49) == 0)
        send_req(ACT_UNUSED, 8'($urandom), 1'($urandom), 9'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_scenario();
    int unsigned size;
    size = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(6, 60);
    build_packet(size, 1'b0);
    load_packet();
    exercise_names($urandom_range(4, 10));
  endtask

  // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Response checks and the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.status, rsp_ch.end_offset, rsp_ch.name_length,
                      rsp_ch.read_byte);
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase, phase_goal;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_LOAD;
    req_ch.packet_byte = 8'h00;
    req_ch.first_byte = 1'b0;
    req_ch.start_offset = 9'd0;
    req_ch.read_index = 8'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on the hand-made packet.
    foreach (DEMO_PKT[i]) load_byte(DEMO_PKT[i], i == 0);
    decode_at(9'd0);
    read_at(8'd1);
    read_at(8'd7);
    read_at(8'd8);
    read_at(8'd255);
    decode_at(9'd7);
    decode_at(9'd8);
    read_at(8'd2);
    decode_at(9'd12);
    decode_at(9'd14);
    decode_at(9'd15);
    decode_at(9'd17);
    read_at(8'd0);
    decode_at(9'd511);
    send_req(ACT_UNUSED, 8'hFF, 1'b1, 9'h1FF, 8'hFF);
    // A pointer byte with nothing after it.
    load_byte(8'hC0, 1'b1);
    decode_at(9'd0);

    // Random part in four pacing phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 20; stall_pct = 20; end
      endcase
      if (phase == 0) begin
        // Full packet under a long receiver hold-off, then loads past the end.
        build_packet(FULL_BODY, 1'b1);
        append_byte(8'h01);
        append_byte(8'h5A);
        append_byte(8'h00);
        note_start(FULL_BODY);
        hold_request = 1'b1;
        load_packet();
        load_byte(8'($urandom), 1'b0);
        load_byte(8'($urandom), 1'b0);
        decode_at(9'(FULL_BODY));
        exercise_names(6);
        phase_goal = items_sent;
      end else begin
        phase_goal = items_sent + 20;
      end
      while (items_sent < phase_goal) run_scenario();
    end

    // Drain the outstanding answers, then watch for stray beats.
    req_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: dns_name_decompressor_unit.f
sv/dnd_pkg.sv
sv/dnd_if.sv
sv/dnd_ram.sv
sv/dns_name_decompressor_unit.sv
bench/dnd_check_pkg.sv
bench/tb_top.sv
